/* hdl/mjpq_pkg.sv */
package mjpq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int TIME_WIDTH  = 48;
    localparam int IDX_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int MAX_RESULTS = 16;
    localparam logic [TIME_WIDTH-1:0] TIME_MAX = {TIME_WIDTH{1'b1}};

    typedef enum logic [1:0] {
        MODE_TIMED = 2'd0,
        MODE_IMMED = 2'd1,
        MODE_TICK  = 2'd2,
        MODE_RESET = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        ST_DELIVERED = 2'd0,
        ST_ACCEPTED  = 2'd1,
        ST_DROPPED   = 2'd2,
        ST_EMPTY     = 2'd3
    } status_t;

    typedef struct packed {
        logic [1:0]  mode;
        logic [47:0] sender_time;
        logic [23:0] msg_data;
        logic [1:0]  msg_len;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [23:0] out_data;
        logic [1:0]  out_len;
        logic        last;
    } out_item_t;

    typedef enum logic [1:0] {
        CMD_ECHO,
        CMD_ENQ,
        CMD_TICK,
        CMD_CLEAR
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t             kind;
        logic [1:0]            status;
        logic [TIME_WIDTH-1:0] deadline;
        logic [23:0]           bytes;
        logic [1:0]            len;
    } cmd_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_SCAN,
        BK_EMIT
    } back_state_t;

    function automatic logic [23:0] mask_bytes(logic [23:0] d, logic [1:0] len);
        logic [23:0] r;
        begin
            case (len)
                2'd1:    r = {16'd0, d[7:0]};
                2'd2:    r = {8'd0, d[15:0]};
                2'd3:    r = d;
                default: r = '0;
            endcase
            return r;
        end
    endfunction

endpackage

/* hdl/mjpq_front.sv */
module mjpq_front
    import mjpq_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  in_item_t   in_item,
    input  logic [15:0] jitter_delay,
    input  logic [TIME_WIDTH-1:0] current_time,
    output logic       cmd_valid,
    input  logic       cmd_ready,
    output cmd_t       cmd
);

    typedef enum logic [1:0] {
        FR_IDLE,
        FR_CALC,
        FR_DLINE,
        FR_SEND
    } front_state_t;

    front_state_t          state_reg, state_next;
    in_item_t              item_reg, item_next;
    cmd_t                  cmd_reg, cmd_next;
    logic                  ready_reg, ready_next;
    logic [TIME_WIDTH-1:0] origin_reg, origin_next;
    logic [TIME_WIDTH-1:0] anchor_reg, anchor_next;
    logic [TIME_WIDTH-1:0] diff_reg, diff_next;

    logic [TIME_WIDTH:0]   anc_sum;
    logic [TIME_WIDTH-1:0] mag;
    logic [TIME_WIDTH:0]   add_sum;
    logic [TIME_WIDTH-1:0] dl;
    logic [23:0]           mbytes;

    assign in_stall  = (state_reg != FR_IDLE);
    assign cmd_valid = (state_reg == FR_SEND);
    assign cmd       = cmd_reg;
    assign anc_sum   = {1'b0, current_time} + {{(TIME_WIDTH-15){1'b0}}, jitter_delay};
    assign mag       = ~diff_reg + 1'b1;
    assign add_sum   = {1'b0, anchor_reg} + {1'b0, diff_reg};
    assign mbytes    = mask_bytes(item_reg.msg_data, item_reg.msg_len);

    always_comb
    begin
        if (diff_reg[TIME_WIDTH-1])
        begin
            dl = (mag > anchor_reg) ? current_time : anchor_reg - mag;
        end
        else
        begin
            dl = add_sum[TIME_WIDTH] ? TIME_MAX : add_sum[TIME_WIDTH-1:0];
        end
        if (dl < current_time)
        begin
            dl = current_time;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        item_next   = item_reg;
        cmd_next    = cmd_reg;
        ready_next  = ready_reg;
        origin_next = origin_reg;
        anchor_next = anchor_reg;
        diff_next   = diff_reg;
        unique case (state_reg)
            FR_IDLE:
            begin
                if (in_valid)
                begin
                    item_next = in_item;
                    state_next = FR_CALC;
                end
            end
            FR_CALC:
            begin
                cmd_next.bytes    = mbytes;
                cmd_next.len      = item_reg.msg_len;
                cmd_next.status   = ST_ACCEPTED;
                cmd_next.deadline = current_time;
                state_next        = FR_SEND;
                unique case (mode_t'(item_reg.mode))
                    MODE_TICK:  cmd_next.kind = CMD_TICK;
                    MODE_RESET:
                    begin
                        cmd_next.kind = CMD_CLEAR;
                        ready_next    = 1'b0;
                        origin_next   = '0;
                        anchor_next   = '0;
                    end
                    default:
                    begin
                        if (item_reg.msg_len == 2'd0)
                        begin
                            cmd_next.kind   = CMD_ECHO;
                            cmd_next.status = ST_EMPTY;
                        end
                        else if (item_reg.mode == MODE_IMMED)
                        begin
                            cmd_next.kind = CMD_ENQ;
                        end
                        else
                        begin
                            cmd_next.kind = CMD_ENQ;
                            state_next    = FR_DLINE;
                            if (!ready_reg)
                            begin
                                ready_next  = 1'b1;
                                origin_next = item_reg.sender_time[TIME_WIDTH-1:0];
                                anchor_next = anc_sum[TIME_WIDTH] ? TIME_MAX
                                                                  : anc_sum[TIME_WIDTH-1:0];
                                diff_next   = '0;
                            end
                            else
                            begin
                                diff_next = item_reg.sender_time[TIME_WIDTH-1:0] - origin_reg;
                            end
                        end
                    end
                endcase
            end
            FR_DLINE:
            begin
                cmd_next.deadline = dl;
                state_next        = FR_SEND;
            end
            FR_SEND:
            begin
                if (cmd_ready)
                begin
                    state_next = FR_IDLE;
                end
            end
            default: state_next = FR_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= FR_IDLE;
            ready_reg  <= 1'b0;
            origin_reg <= '0;
            anchor_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            ready_reg  <= ready_next;
            origin_reg <= origin_next;
            anchor_reg <= anchor_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        cmd_reg  <= cmd_next;
        diff_reg <= diff_next;
    end

endmodule

/* hdl/mjpq_back.sv */
module mjpq_back
    import mjpq_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cmd_valid,
    output logic       cmd_ready,
    input  cmd_t       cmd,
    output logic [TIME_WIDTH-1:0] current_time,
    output logic       out_valid,
    input  logic       out_stall,
    output out_item_t  out_item
);

    back_state_t           state_reg, state_next;
    logic [TIME_WIDTH-1:0] time_reg, time_next;
    logic [7:0]            arr_reg, arr_next;
    logic [QUEUE_DEPTH-1:0] valid_reg, valid_next;
    logic [TIME_WIDTH-1:0] dl_reg [QUEUE_DEPTH];
    logic [23:0]           by_reg [QUEUE_DEPTH];
    logic [1:0]            ln_reg [QUEUE_DEPTH];
    logic [7:0]            ord_reg [QUEUE_DEPTH];
    logic                  wr_en;
    logic [IDX_W-1:0]      wr_idx;
    logic [IDX_W-1:0]      scan_reg, scan_next;
    logic                  found_reg, found_next;
    logic [IDX_W-1:0]      best_reg, best_next;
    logic [7:0]            bage_reg, bage_next;
    logic [CNT_W-1:0]      n_reg, n_next;
    logic                  ov_reg, ov_next;
    out_item_t             oi_reg, oi_next;
    logic                  pend_reg, pend_next;
    out_item_t             pend_item_reg, pend_item_next;
    logic                  full;
    logic [IDX_W-1:0]      free_idx;
    logic [7:0]            age;
    logic                  take;

    assign current_time = time_reg;
    assign out_valid    = ov_reg;
    assign out_item     = oi_reg;
    assign age          = arr_reg - ord_reg[scan_reg];

    always_comb
    begin
        full = 1'b1;
        free_idx = '0;
        for (int i = QUEUE_DEPTH - 1; i >= 0; i--)
        begin
            if (!valid_reg[i])
            begin
                full = 1'b0;
                free_idx = IDX_W'(i);
            end
        end
    end

    always_comb
    begin
        take = valid_reg[scan_reg] && dl_reg[scan_reg] <= time_reg;
        if (take && found_reg)
        begin
            take = dl_reg[scan_reg] < dl_reg[best_reg] ||
                   (dl_reg[scan_reg] == dl_reg[best_reg] && age > bage_reg);
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        time_next      = time_reg;
        arr_next       = arr_reg;
        valid_next     = valid_reg;
        scan_next      = scan_reg;
        found_next     = found_reg;
        best_next      = best_reg;
        bage_next      = bage_reg;
        n_next         = n_reg;
        ov_next        = ov_reg;
        oi_next        = oi_reg;
        pend_next      = pend_reg;
        pend_item_next = pend_item_reg;
        cmd_ready      = 1'b0;
        wr_en          = 1'b0;
        wr_idx         = free_idx;
        if (ov_reg && !out_stall)
        begin
            ov_next = 1'b0;
        end
        unique case (state_reg)
            BK_IDLE:
            begin
                if (cmd_valid && !ov_next)
                begin
                    cmd_ready = 1'b1;
                    unique case (cmd.kind)
                        CMD_ECHO:
                        begin
                            ov_next = 1'b1;
                            oi_next = '{status: cmd.status, out_data: cmd.bytes,
                                        out_len: cmd.len, last: 1'b1};
                        end
                        CMD_ENQ:
                        begin
                            ov_next = 1'b1;
                            oi_next = '{status: full ? ST_DROPPED : ST_ACCEPTED,
                                        out_data: cmd.bytes, out_len: cmd.len, last: 1'b1};
                            if (!full)
                            begin
                                wr_en = 1'b1;
                                valid_next[free_idx] = 1'b1;
                                arr_next = arr_reg + 8'd1;
                            end
                        end
                        CMD_CLEAR: valid_next = '0;
                        CMD_TICK:
                        begin
                            if (time_reg != TIME_MAX)
                            begin
                                time_next = time_reg + 1'b1;
                            end
                            n_next     = '0;
                            pend_next  = 1'b0;
                            scan_next  = '0;
                            found_next = 1'b0;
                            state_next = BK_SCAN;
                        end
                        default: ;
                    endcase
                end
            end
            BK_SCAN:
            begin
                if (take)
                begin
                    found_next = 1'b1;
                    best_next  = scan_reg;
                    bage_next  = age;
                end
                scan_next = scan_reg + 1'b1;
                if (scan_reg == IDX_W'(QUEUE_DEPTH - 1))
                begin
                    state_next = BK_EMIT;
                end
            end
            BK_EMIT:
            begin
                if (!ov_next || !pend_reg)
                begin
                    if (pend_reg && !found_reg)
                    begin
                        ov_next = 1'b1;
                        oi_next = pend_item_reg;
                        oi_next.last = 1'b1;
                        pend_next = 1'b0;
                        state_next = BK_IDLE;
                    end
                    else if (!found_reg)
                    begin
                        state_next = BK_IDLE;
                    end
                    else
                    begin
                        if (pend_reg)
                        begin
                            ov_next = 1'b1;
                            oi_next = pend_item_reg;
                        end
                        valid_next[best_reg] = 1'b0;
                        pend_next = 1'b1;
                        pend_item_next = '{status: ST_DELIVERED, out_data: by_reg[best_reg],
                                           out_len: ln_reg[best_reg], last: 1'b0};
                        n_next = n_reg + 1'b1;
                        scan_next  = '0;
                        found_next = 1'b0;
                        state_next = (n_reg + 1'b1 == CNT_W'(MAX_RESULTS)) ? BK_EMIT : BK_SCAN;
                        if (n_reg + 1'b1 == CNT_W'(MAX_RESULTS))
                        begin
                            found_next = 1'b0;
                        end
                    end
                end
            end
            default: state_next = BK_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BK_IDLE;
            time_reg  <= '0;
            arr_reg   <= '0;
            valid_reg <= '0;
            ov_reg    <= 1'b0;
            pend_reg  <= 1'b0;
            n_reg     <= '0;
            found_reg <= 1'b0;
            scan_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            time_reg  <= time_next;
            arr_reg   <= arr_next;
            valid_reg <= valid_next;
            ov_reg    <= ov_next;
            pend_reg  <= pend_next;
            n_reg     <= n_next;
            found_reg <= found_next;
            scan_reg  <= scan_next;
        end
    end

    always_ff @(posedge clk)
    begin
        best_reg      <= best_next;
        bage_reg      <= bage_next;
        oi_reg        <= oi_next;
        pend_item_reg <= pend_item_next;
        if (wr_en)
        begin
            dl_reg[wr_idx]  <= cmd.deadline;
            by_reg[wr_idx]  <= cmd.bytes;
            ln_reg[wr_idx]  <= cmd.len;
            ord_reg[wr_idx] <= arr_reg;
        end
    end

endmodule

/* hdl/midi_jitter_playout_queue_top.sv */
// MIDI playout queue: messages of up to three bytes are held until their
// deadline (session anchor plus sender offset) and released on time ticks,
// earliest deadline first. The front stage passes each accepted request
// through its calculation state (and, for a timed message, its deadline
// state) before offering it to the back stage, and stalls the input until
// the back stage has taken it. A tick scans all sixteen queue entries once
// per delivered message (at most sixteen), plus once more to find nothing
// left due unless sixteen were delivered; the back stage takes no new
// command until the tick is done, which lasts longer while the output is stalled.
module midi_jitter_playout_queue_top
    import mjpq_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  in_item_t    in_item,
    output logic        out_valid,
    input  logic        out_stall,
    output out_item_t   out_item,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data
);

    logic [15:0]           delay_reg;
    logic                  cmd_valid;
    logic                  cmd_ready;
    cmd_t                  cmd;
    logic [TIME_WIDTH-1:0] current_time;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delay_reg <= '0;
        end
        else if (cfg_valid)
        begin
            delay_reg <= cfg_data;
        end
    end

    mjpq_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .in_item      (in_item),
        .jitter_delay (delay_reg),
        .current_time (current_time),
        .cmd_valid    (cmd_valid),
        .cmd_ready    (cmd_ready),
        .cmd          (cmd)
    );

    mjpq_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd_valid    (cmd_valid),
        .cmd_ready    (cmd_ready),
        .cmd          (cmd),
        .current_time (current_time),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_item     (out_item)
    );

endmodule

/* sim/midi_jitter_playout_queue_top_tb.sv */
module midi_jitter_playout_queue_top_tb
    import mjpq_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [47:0] TMAX = 48'hFFFF_FFFF_FFFF;
    localparam int DRAIN_CYCLES = 400;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int TICK_ROUNDS = 40;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    in_item_t    in_item;
    logic        out_valid;
    logic        out_stall;
    out_item_t   out_item;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [15:0] cfg_data;

    midi_jitter_playout_queue_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // playout model state
    logic [15:0] pm_delay;
    logic        pm_ready;
    logic [47:0] pm_origin;
    logic [47:0] pm_anchor;
    logic [47:0] pm_now;
    logic [47:0] pm_deadline [QUEUE_DEPTH];
    logic [23:0] pm_bytes [QUEUE_DEPTH];
    logic [1:0]  pm_len [QUEUE_DEPTH];
    logic [7:0]  pm_order [QUEUE_DEPTH];
    logic        pm_valid [QUEUE_DEPTH];
    logic [7:0]  pm_arrivals;

    out_item_t expected_results [$];
    int  mismatches;
    int  idle_cycles;
    int  hold_cycles;
    bit  timed_out;

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    function automatic logic [47:0] add_sat(logic [47:0] a, logic [47:0] b);
        logic [48:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[48] ? TMAX : s[47:0];
    endfunction

    function automatic logic [23:0] keep_bytes(logic [23:0] d, logic [1:0] n);
        case (n)
            2'd1:    return {16'd0, d[7:0]};
            2'd2:    return {8'd0, d[15:0]};
            2'd3:    return d;
            default: return 24'd0;
        endcase
    endfunction

    function automatic out_item_t result_of(status_t st, logic [23:0] d, logic [1:0] n,
                                            logic lst);
        out_item_t r;
        r.status = st;
        r.out_data = d;
        r.out_len = n;
        r.last = lst;
        return r;
    endfunction

    task automatic predict_playout(in_item_t it);
        logic [23:0] b;
        logic [47:0] dl;
        logic [47:0] diff;
        logic [47:0] mag;
        logic [7:0]  age;
        logic [7:0]  best_age;
        int best;
        int n;
        bit placed;
        b = keep_bytes(it.msg_data, it.msg_len);
        case (mode_t'(it.mode))
            MODE_TIMED, MODE_IMMED:
            begin
                if (it.msg_len == 2'd0) begin
                    expected_results.push_back(result_of(ST_EMPTY, 24'd0, 2'd0, 1'b1));
                end else begin
                    if (it.mode == MODE_TIMED) begin
                        if (!pm_ready) begin
                            pm_ready = 1'b1;
                            pm_origin = it.sender_time;
                            pm_anchor = add_sat(pm_now, {32'd0, pm_delay});
                        end
                        diff = it.sender_time - pm_origin;
                        if (diff[47]) begin
                            mag = -diff;
                            dl = (mag > pm_anchor) ? pm_now : pm_anchor - mag;
                        end else begin
                            dl = add_sat(pm_anchor, diff);
                        end
                        if (dl < pm_now) dl = pm_now;
                    end else begin
                        dl = pm_now;
                    end
                    placed = 1'b0;
                    for (int i = 0; i < QUEUE_DEPTH; i++) begin
                        if (!placed && !pm_valid[i]) begin
                            placed = 1'b1;
                            pm_valid[i] = 1'b1;
                            pm_deadline[i] = dl;
                            pm_bytes[i] = b;
                            pm_len[i] = it.msg_len;
                            pm_order[i] = pm_arrivals;
                            pm_arrivals++;
                        end
                    end
                    expected_results.push_back(result_of(placed ? ST_ACCEPTED : ST_DROPPED,
                                                         b, it.msg_len, 1'b1));
                end
            end
            MODE_RESET:
            begin
                pm_ready = 1'b0;
                pm_origin = '0;
                pm_anchor = '0;
                for (int i = 0; i < QUEUE_DEPTH; i++) pm_valid[i] = 1'b0;
            end
            default:
            begin
                if (pm_now != TMAX) pm_now++;
                n = 0;
                best = 0;
                while (n < MAX_RESULTS && best >= 0) begin
                    best = -1;
                    best_age = 0;
                    for (int i = 0; i < QUEUE_DEPTH; i++) begin
                        if (pm_valid[i] && pm_deadline[i] <= pm_now) begin
                            age = pm_arrivals - pm_order[i];
                            if (best < 0 || pm_deadline[i] < pm_deadline[best] ||
                                (pm_deadline[i] == pm_deadline[best] && age > best_age)) begin
                                best = i;
                                best_age = age;
                            end
                        end
                    end
                    if (best >= 0) begin
                        pm_valid[best] = 1'b0;
                        expected_results.push_back(result_of(ST_DELIVERED, pm_bytes[best],
                                                             pm_len[best], 1'b0));
                        n++;
                    end
                end
                if (n > 0) expected_results[$].last = 1'b1;
            end
        endcase
    endtask

    task automatic send_request(in_item_t it);
        int gap;
        gap = $urandom_range(0, 15);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item <= it;
        do @(posedge clk); while (in_stall);
        predict_playout(it);
    endtask

    task automatic send_fields(mode_t m, logic [47:0] t, logic [23:0] d, logic [1:0] n);
        in_item_t it;
        it.mode = m;
        it.sender_time = t;
        it.msg_data = d;
        it.msg_len = n;
        send_request(it);
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (expected_results.size() != 0 && !timed_out) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_delay(logic [15:0] v);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        do @(posedge clk); while (!cfg_ready);
        pm_delay = v;
        cfg_valid <= 1'b0;
    endtask

    task automatic tick_until_empty();
        bit busy;
        int rounds;
        busy = 1'b1;
        rounds = 0;
        while (busy && rounds < TICK_ROUNDS) begin
            send_fields(MODE_TICK, '0, '0, 2'd0);
            rounds++;
            busy = 1'b0;
            for (int i = 0; i < QUEUE_DEPTH; i++) busy |= pm_valid[i];
        end
        if (busy)
        begin
            send_fields(MODE_RESET, '0, '0, 2'd0);
        end
    endtask

    task automatic test_directed_edges();
        send_fields(MODE_TIMED, 48'd5, 24'hFFFFFF, 2'd0);
        send_fields(MODE_IMMED, TMAX, 24'hABCDEF, 2'd1);
        send_fields(MODE_TIMED, TMAX, 24'hFFFFFF, 2'd3);
        send_fields(MODE_TIMED, 48'd0, 24'h123456, 2'd2);
        send_fields(MODE_TIMED, TMAX - 48'd3, 24'h000001, 2'd1);
        send_fields(MODE_TIMED, 48'h7FFF_FFFF_FFFF, 24'h555555, 2'd3);
        send_fields(MODE_TICK, '0, '0, 2'd0);
        send_fields(MODE_TICK, '0, '0, 2'd0);
        send_fields(MODE_RESET, TMAX, 24'hFFFFFF, 2'd3);
        send_fields(MODE_TICK, '0, '0, 2'd0);
        wait_idle();
    endtask

    task automatic test_full_queue_and_burst();
        for (int i = 0; i < QUEUE_DEPTH + 2; i++)
            send_fields(MODE_IMMED, '0, 24'($urandom), 2'($urandom_range(1, 3)));
        send_fields(MODE_TICK, '0, '0, 2'd0);
        send_fields(MODE_TICK, '0, '0, 2'd0);
        send_fields(MODE_RESET, '0, '0, 2'd0);
        wait_idle();
    endtask

    task automatic test_back_pressure();
        hold_cycles = 600;
        for (int i = 0; i < 12; i++)
            send_fields(MODE_IMMED, '0, 24'($urandom), 2'($urandom_range(0, 3)));
        send_fields(MODE_TICK, '0, '0, 2'd0);
        wait_idle();
    endtask

    task automatic test_random_sessions(int count);
        logic [47:0] base;
        int r;
        base = 48'({$urandom, $urandom});
        for (int i = 0; i < count; i++) begin
            r = $urandom_range(0, 99);
            if (r < 50)
                send_fields(MODE_TIMED, base + 48'($urandom_range(0, 12)) - 48'd3,
                            24'($urandom), 2'($urandom_range(0, 3)));
            else if (r < 58)
                send_fields(MODE_TIMED, 48'({$urandom, $urandom}), 24'($urandom),
                            2'($urandom_range(0, 3)));
            else if (r < 68)
                send_fields(MODE_IMMED, 48'({$urandom, $urandom}), 24'($urandom),
                            2'($urandom_range(0, 3)));
            else if (r < 97)
                send_fields(MODE_TICK, 48'({$urandom, $urandom}), 24'($urandom),
                            2'($urandom));
            else begin
                send_fields(MODE_RESET, 48'({$urandom, $urandom}), 24'($urandom),
                            2'($urandom));
                base = 48'({$urandom, $urandom});
            end
        end
        tick_until_empty();
        wait_idle();
    endtask

    task automatic test_clock_end();
        write_delay(16'hFFFF);
        send_fields(MODE_TIMED, 48'd100, 24'h010203, 2'd3);
        send_fields(MODE_TIMED, 48'd99, 24'h0A0B0C, 2'd2);
        send_fields(MODE_TIMED, 48'd101, 24'h0D0E0F, 2'd1);
        send_fields(MODE_RESET, '0, '0, 2'd0);
        wait_idle();
    endtask

    initial begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_item = '0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        pm_delay = '0;
        pm_ready = 1'b0;
        pm_origin = '0;
        pm_anchor = '0;
        pm_now = '0;
        pm_arrivals = '0;
        for (int i = 0; i < QUEUE_DEPTH; i++) pm_valid[i] = 1'b0;
        mismatches = 0;
        hold_cycles = 0;
        timed_out = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_edges();
        write_delay(16'd0);
        test_full_queue_and_burst();
        write_delay(16'd4);
        test_back_pressure();
        test_random_sessions(150);
        write_delay(16'd1);
        test_random_sessions(130);
        write_delay(16'd9);
        test_random_sessions(130);
        test_clock_end();

        if (mismatches == 0 && expected_results.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // receiver: random stall per result, with one long hold-off on request
    initial begin
        int wait_n;
        out_stall = 1'b1;
        @(posedge rst_n);
        forever begin
            if (hold_cycles > 0) begin
                out_stall <= 1'b1;
                repeat (hold_cycles) @(posedge clk);
                hold_cycles = 0;
            end
            wait_n = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 15);
            if (wait_n > 0)
            begin
                out_stall <= 1'b1;
                repeat (wait_n) @(posedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!out_valid);
        end
    end

    always @(posedge clk) begin
        out_item_t exp_r;
        if (rst_n && out_valid && !out_stall) begin
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %p", out_item);
            end else begin
                exp_r = expected_results.pop_front();
                if (out_item.status !== exp_r.status || out_item.out_data !== exp_r.out_data ||
                    out_item.out_len !== exp_r.out_len || out_item.last !== exp_r.last) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %p actual %p", exp_r, out_item);
                end
            end
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
            hold_cycles > 0)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            timed_out = 1'b1;
            $display("Some tests failed");
            $finish;
        end
    end

endmodule

/* files.f */
hdl/mjpq_pkg.sv
hdl/mjpq_front.sv
hdl/mjpq_back.sv
hdl/midi_jitter_playout_queue_top.sv
sim/midi_jitter_playout_queue_top_tb.sv
